/* rtl/htx_pkg.sv */
// Package for the HDLC transmit bit stuffer with CRC-16.
// Holds the item types, the codes and the byte stepping function.
// Depends on nothing; used by htx_out_q and hdlc_tx_bit_stuffer_crc_core.
`timescale 1ns / 1ps

package htx_pkg;

  typedef enum logic [1:0] {
    KIND_RAW  = 2'd0,
    KIND_DATA = 2'd1,
    KIND_END  = 2'd2,
    KIND_SEED = 2'd3
  } kind_t;

  localparam logic CFG_CRC_POLY = 1'b0;
  localparam logic CFG_CRC_SEED = 1'b1;

  localparam logic [15:0] CRC_POLY_RESET = 16'h8408;
  localparam logic [15:0] CRC_SEED_RESET = 16'hFFFF;
  localparam logic [2:0]  STUFF_LIMIT    = 3'd5;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
  } src_item_t;

  typedef struct packed {
    logic [9:0]  line_bits;
    logic [3:0]  bit_count;
    logic        last;
  } res_item_t;

  typedef struct packed {
    logic [15:0] crc;
    logic [2:0]  run;
    logic [9:0]  bits;
    logic [3:0]  count;
  } step_t;

  // Sends one byte LSB first. Data bytes step the reflected CRC and get a
  // zero inserted after five ones in a row; raw bytes do neither.
  function automatic step_t htx_emit_byte(input logic [15:0] crc,
                                          input logic [2:0]  run,
                                          input logic [7:0]  byte_in,
                                          input logic        is_data,
                                          input logic [15:0] poly);
    logic [15:0] c;
    logic [2:0]  r;
    logic [9:0]  b;
    logic [3:0]  n;
    logic        bi;
    logic        fb;
    step_t       s;
    c = crc;
    r = run;
    b = '0;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      bi = byte_in[i];
      if (!is_data) begin
        r = '0;
      end else begin
        fb = c[0] ^ bi;
        c  = {1'b0, c[15:1]};
        if (fb) begin
          c = c ^ poly;
        end
      end
      if (!bi) begin
        r = '0;
        n = n + 4'd1;
      end else begin
        b[n] = 1'b1;
        n = n + 4'd1;
        r = r + 3'd1;
        if (r >= STUFF_LIMIT) begin
          r = '0;
          n = n + 4'd1;
        end
      end
    end
    s.crc   = c;
    s.run   = r;
    s.bits  = b;
    s.count = n;
    return s;
  endfunction

endpackage

/* rtl/hdlc_tx_bit_stuffer_crc_core.sv */
// Top level of the HDLC transmit bit stuffer with reflected CRC-16.
// Depends on htx_pkg and htx_out_q.
//
// Raw, data and reseed items are taken one per clock cycle; each raw or data
// item yields one result of 8 to 10 line bits, and a reseed item yields none.
// An end item is handled in two steps: the first sends the inverted low CRC
// byte, the second sends the high byte, held from the moment the item was
// taken, through the same byte stepping logic while the input is stalled.
// Results go through a two-entry queue, so a new item is taken while one
// result waits; apart from the pending high byte of an end item, the input
// stalls only when that queue is full.
`timescale 1ns / 1ps

module hdlc_tx_bit_stuffer_crc_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                src_valid,
  output logic                src_stall,
  input  htx_pkg::src_item_t  src_item,
  output logic                res_valid,
  input  logic                res_stall,
  output htx_pkg::res_item_t  res_item,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data
);
  import htx_pkg::*;

  logic [15:0] crc_poly;
  logic [15:0] crc_seed;
  logic [15:0] crc_reg;
  logic [2:0]  ones_run;
  logic        pend_hi;
  logic [7:0]  hi_byte;

  logic        q_full;
  logic        src_accept;
  logic        push;
  logic [7:0]  sel_byte;
  logic        sel_data;
  logic        sel_last;
  step_t       step;
  res_item_t   step_item;

  assign src_stall  = pend_hi | q_full;
  assign src_accept = src_valid & ~src_stall;

  always_comb begin
    if (pend_hi) begin
      sel_byte = hi_byte;
      sel_data = 1'b1;
      sel_last = 1'b1;
    end else if (src_item.kind == KIND_END) begin
      sel_byte = ~crc_reg[7:0];
      sel_data = 1'b1;
      sel_last = 1'b0;
    end else begin
      sel_byte = src_item.data_byte;
      sel_data = (src_item.kind == KIND_DATA);
      sel_last = 1'b1;
    end
  end

  assign step = htx_emit_byte(crc_reg, ones_run, sel_byte, sel_data, crc_poly);

  assign push = pend_hi ? ~q_full : (src_accept & (src_item.kind != KIND_SEED));

  always_comb begin
    step_item.line_bits = step.bits;
    step_item.bit_count = step.count;
    step_item.last      = sel_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_poly <= CRC_POLY_RESET;
      crc_seed <= CRC_SEED_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CRC_POLY: crc_poly <= cfg_data;
        CFG_CRC_SEED: crc_seed <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_reg  <= CRC_SEED_RESET;
      ones_run <= 3'd0;
      pend_hi  <= 1'b0;
    end else begin
      if (push) begin
        crc_reg  <= step.crc;
        ones_run <= step.run;
      end else if (src_accept && src_item.kind == KIND_SEED) begin
        crc_reg <= crc_seed;
      end
      if (src_accept && src_item.kind == KIND_END) begin
        pend_hi <= 1'b1;
      end else if (pend_hi && push) begin
        pend_hi <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (src_accept && src_item.kind == KIND_END) begin
      hi_byte <= ~crc_reg[15:8];
    end
  end

  htx_out_q u_out_q (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .din       (step_item),
    .full      (q_full),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

`ifndef SYNTH
  a_end_sets_pending: assert property (@(posedge clk) disable iff (rst)
    (src_accept && src_item.kind == KIND_END) |=> pend_hi)
    else $error("end item did not schedule the high CRC byte");

  a_seed_loads_crc: assert property (@(posedge clk) disable iff (rst)
    (src_accept && src_item.kind == KIND_SEED) |=> crc_reg == $past(crc_seed))
    else $error("reseed item did not load the CRC register");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_item.bit_count == 4'd8 || res_item.bit_count == 4'd9 ||
                   res_item.bit_count == 4'd10))
    else $error("result bit count out of range");

  a_run_below_limit: assert property (@(posedge clk) disable iff (rst)
    ones_run < STUFF_LIMIT)
    else $error("ones run reached the stuffing limit");
`endif

endmodule

/* rtl/htx_out_q.sv */
// Two-entry result queue for the HDLC transmit bit stuffer.
// Holds finished result items so the input side keeps moving while one waits.
// Depends on htx_pkg.
`timescale 1ns / 1ps

module htx_out_q (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  htx_pkg::res_item_t  din,
  output logic                full,
  output logic                res_valid,
  input  logic                res_stall,
  output htx_pkg::res_item_t  res_item
);
  import htx_pkg::*;

  res_item_t   q0;
  res_item_t   q1;
  logic [1:0]  level;
  logic [1:0]  level_next;
  logic        pop;

  assign pop       = res_valid & ~res_stall;
  assign res_valid = (level != 2'd0);
  assign full      = (level == 2'd2);
  assign res_item  = q0;

  always_comb begin
    level_next = level;
    case ({push, pop})
      2'b10:   level_next = level + 2'd1;
      2'b01:   level_next = level - 2'd1;
      default: level_next = level;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= 2'd0;
    end else begin
      level <= level_next;
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b11: begin
        if (level == 2'd1) begin
          q0 <= din;
        end else begin
          q0 <= q1;
          q1 <= din;
        end
      end
      2'b10: begin
        if (level == 2'd0) begin
          q0 <= din;
        end else begin
          q1 <= din;
        end
      end
      2'b01: begin
        q0 <= q1;
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTH
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("item pushed into a full result queue");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    level != 2'd3)
    else $error("result queue level out of range");

  a_push_shows_valid: assert property (@(posedge clk) disable iff (rst)
    push |=> res_valid)
    else $error("pushed item not visible at the output");
`endif

endmodule

/* test/tb_hdlc_tx_bit_stuffer_crc_core.sv */
// Self-checking testbench for hdlc_tx_bit_stuffer_crc_core: a scoreboard class predicts
// every line-bit chunk from the accepted items and the register settings.
// Depends on htx_pkg and the RTL of the core.
`timescale 1ns / 1ps

class hdlc_line_scoreboard;
  logic [15:0] poly;
  logic [15:0] seed;
  logic [15:0] crc;
  logic [2:0]  run;
  htx_pkg::res_item_t pending[$];
  int errors;

  function new();
    poly = htx_pkg::CRC_POLY_RESET;
    seed = htx_pkg::CRC_SEED_RESET;
    crc = 16'hFFFF;
    run = '0;
    errors = 0;
  endfunction

  function void write_reg(logic idx, logic [15:0] value);
    if (idx == htx_pkg::CFG_CRC_POLY) begin
      poly = value;
    end else begin
      seed = value;
    end
  endfunction

  function void emit_chunk(logic [7:0] byte_in, bit is_data, bit last_flag);
    logic [9:0] line;
    int pos;
    logic b;
    htx_pkg::res_item_t r;
    line = '0;
    pos = 0;
    for (int i = 0; i < 8; i++) begin
      b = byte_in[i];
      if (is_data) begin
        if (crc[0] ^ b) begin
          crc = (crc >> 1) ^ poly;
        end else begin
          crc = crc >> 1;
        end
      end else begin
        run = '0;
      end
      if (b) begin
        line[pos] = 1'b1;
        pos++;
        if (run == 3'd4) begin
          run = '0;
          pos++;
        end else begin
          run = run + 3'd1;
        end
      end else begin
        run = '0;
        pos++;
      end
    end
    r.line_bits = line;
    r.bit_count = pos[3:0];
    r.last = last_flag;
    pending.push_back(r);
  endfunction

  function void note_input(htx_pkg::src_item_t it);
    logic [7:0] lo;
    logic [7:0] hi;
    case (it.kind)
      htx_pkg::KIND_RAW: begin
        emit_chunk(it.data_byte, 1'b0, 1'b1);
      end
      htx_pkg::KIND_DATA: begin
        emit_chunk(it.data_byte, 1'b1, 1'b1);
      end
      htx_pkg::KIND_END: begin
        lo = ~crc[7:0];
        hi = ~crc[15:8];
        emit_chunk(lo, 1'b1, 1'b0);
        emit_chunk(hi, 1'b1, 1'b1);
      end
      default: begin
        crc = seed;
      end
    endcase
  endfunction

  function void check_result(htx_pkg::res_item_t got);
    htx_pkg::res_item_t want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected item line_bits=%h bit_count=%0d last=%0b", $time,
               got.line_bits, got.bit_count, got.last);
      errors++;
    end else begin
      want = pending.pop_front();
      if (got.line_bits !== want.line_bits) begin
        $display("%0t: line_bits expected %h actual %h", $time, want.line_bits, got.line_bits);
        errors++;
      end
      if (got.bit_count !== want.bit_count) begin
        $display("%0t: bit_count expected %0d actual %0d", $time, want.bit_count,
                 got.bit_count);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
        errors++;
      end
    end
  endfunction
endclass

module tb_hdlc_tx_bit_stuffer_crc_core;
  import htx_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 366;

  logic clk;
  logic rst = 1'b1;
  logic src_valid = 1'b0;
  logic src_stall;
  src_item_t src_item = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_item_t res_item;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_CRC_POLY;
  logic [15:0] cfg_data = '0;

  hdlc_line_scoreboard sb;
  bit quiet = 1'b0;
  int items_sent = 0;
  int results_seen = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int cycles = 0;

  hdlc_tx_bit_stuffer_crc_core dut (
    .clk(clk),
    .rst(rst),
    .src_valid(src_valid),
    .src_stall(src_stall),
    .src_item(src_item),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_item(res_item),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("hdlc_tx_bit_stuffer_crc_core test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'($urandom_range(1));
    end else begin
      if (res_valid && !res_stall) begin
        sb.check_result(res_item);
        results_seen <= results_seen + 1;
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        res_stall <= 1'b1;
      end else if (!hold_done && results_seen == 600) begin
        hold_left <= 300;
        hold_done <= 1'b1;
        res_stall <= 1'b1;
      end else begin
        res_stall <= !quiet && ($urandom_range(99) < 29);
      end
    end
  end

  function automatic src_item_t mk(kind_t k, logic [7:0] b);
    src_item_t it;
    it.kind = k;
    it.data_byte = b;
    return it;
  endfunction

  task automatic send_item(input src_item_t it);
    if (!quiet) begin
      while ($urandom_range(99) < 29) begin
        src_valid <= 1'b0;
        @(posedge clk);
      end
    end
    src_valid <= 1'b1;
    src_item <= it;
    @(posedge clk);
    while (src_stall) @(posedge clk);
    sb.note_input(it);
    items_sent++;
  endtask

  task automatic drain();
    src_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_regs(input logic [15:0] poly, input logic [15:0] seed);
    cfg_we <= 1'b1;
    cfg_index <= CFG_CRC_POLY;
    cfg_data <= poly;
    @(posedge clk);
    sb.write_reg(CFG_CRC_POLY, poly);
    cfg_index <= CFG_CRC_SEED;
    cfg_data <= seed;
    @(posedge clk);
    sb.write_reg(CFG_CRC_SEED, seed);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] frame_byte();
    case ($urandom_range(3))
      0: return 8'hFF;
      1: return 8'(8'h1F << $urandom_range(3));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_frame(input bit complete);
    int n;
    repeat ($urandom_range(1, 2)) send_item(mk(KIND_RAW, 8'h7E));
    send_item(mk(KIND_SEED, 8'($urandom_range(255))));
    n = $urandom_range(0, 8);
    repeat (n) send_item(mk(KIND_DATA, frame_byte()));
    if (complete) begin
      send_item(mk(KIND_END, 8'($urandom_range(255))));
    end
    send_item(mk(KIND_RAW, 8'h7E));
  endtask

  task automatic random_phase();
    int stop_at;
    int pick;
    stop_at = items_sent + PHASE_ITEMS;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 78) begin
        send_frame(1'b1);
      end else if (pick < 88) begin
        send_frame(1'b0);
      end else begin
        send_item(mk(kind_t'($urandom_range(3)), 8'($urandom_range(255))));
      end
    end
    drain();
  endtask

  task automatic directed_part();
    send_item(mk(KIND_RAW, 8'h7E));
    send_item(mk(KIND_RAW, 8'h00));
    send_item(mk(KIND_RAW, 8'hFF));
    send_item(mk(KIND_DATA, 8'h00));
    send_item(mk(KIND_DATA, 8'hFF));
    send_item(mk(KIND_DATA, 8'hFF));
    send_item(mk(KIND_DATA, 8'h1F));
    send_item(mk(KIND_DATA, 8'hF8));
    send_item(mk(KIND_RAW, 8'h80));
    send_item(mk(KIND_DATA, 8'h0F));
    send_item(mk(KIND_END, 8'h00));
    send_item(mk(KIND_SEED, 8'hA5));
    send_item(mk(KIND_END, 8'hFF));
    send_item(mk(KIND_RAW, 8'h7E));
    send_item(mk(KIND_SEED, 8'h00));
    send_item(mk(KIND_DATA, 8'h7E));
    send_item(mk(KIND_DATA, 8'h55));
    send_item(mk(KIND_DATA, 8'hAA));
    send_item(mk(KIND_END, 8'h3C));
    send_item(mk(KIND_RAW, 8'hFF));
    send_item(mk(KIND_DATA, 8'h3E));
    send_item(mk(KIND_DATA, 8'h7C));
    send_item(mk(KIND_END, 8'hFF));
    send_item(mk(KIND_RAW, 8'h7E));
    drain();
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_part();
    random_phase();

    write_regs(16'h0000, 16'h0000);
    directed_part();
    random_phase();

    write_regs(16'hFFFF, 16'hFFFF);
    quiet = 1'b1;
    random_phase();
    quiet = 1'b0;

    write_regs(16'h8408, 16'($urandom_range(65535)));
    random_phase();

    write_regs(16'($urandom_range(65535)), 16'($urandom_range(65535)));
    random_phase();

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("hdlc_tx_bit_stuffer_crc_core test passed");
    end else begin
      $display("hdlc_tx_bit_stuffer_crc_core test failed");
    end
    $finish;
  end
endmodule
